/* hw/rtl/sfrq_pkg.sv */
// Shared types and constants for the smallest-first request queue.
package sfrq_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int LIM_W = 5;
  localparam int OCC_W = 5;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic OPC_INSERT = 1'b0;
  localparam logic OPC_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Broadcast to every cell for one accepted beat.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t ins;
  } cell_ctl_t;

endpackage

/* hw/rtl/smallest_first_request_queue.sv */
// Top level: sorted chain of cells with count, capacity register and result register.
//
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+----------------------------------------
// command   | in        | start, busy          | opcode, size_key, request_tag
// result    | out       | done (one cycle)     | status, out_size, out_tag, occupancy
// config    | in        | cfg_we               | cfg_wdata (capacity limit)
//
// All cells compare and shift in parallel on each operation, so a
// command may be started on every clock and its result shows on done the next cycle.
// busy stays low; the cell row is updated in the same edge that takes the command.
// rst (synchronous) clears the entry count, the result strobe and sets the limit to 16.
// The receiver cannot stall: done flags each result for exactly one cycle.
module smallest_first_request_queue
  import sfrq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             opcode,
  input  logic [KEY_W-1:0] size_key,
  input  logic [TAG_W-1:0] request_tag,
  output logic             done,
  output logic [1:0]       status,
  output logic [KEY_W-1:0] out_size,
  output logic [TAG_W-1:0] out_tag,
  output logic [OCC_W-1:0] occupancy,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [LIM_W-1:0] capacity_limit;

  logic             accept;
  logic             full;
  logic             empty;
  cell_ctl_t        ctl;
  status_t          status_next;

  entry_t           cell_data [DEPTH];
  logic [DEPTH-1:0] cell_gt;
  logic [DEPTH-1:0] cell_occ;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (count == '0);
  assign full   = (CMP_W'(count) >= CMP_W'(capacity_limit)) || (count == CNT_W'(DEPTH));

  always_comb begin
    ctl.insert  = accept && (opcode == OPC_INSERT) && !full;
    ctl.remove  = accept && (opcode == OPC_REMOVE) && !empty;
    ctl.ins.key = size_key;
    ctl.ins.tag = request_tag;
  end

  always_comb begin
    count_next = count;
    priority if (ctl.insert) begin
      count_next = count + 1'b1;
    end else if (ctl.remove) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    if (opcode == OPC_INSERT) begin
      status_next = full ? ST_FULL : ST_INSERTED;
    end else begin
      status_next = empty ? ST_EMPTY : ST_REMOVED;
    end
  end

  // Row of cells: each looks at its left neighbour on insert, its right on remove.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_d;
    entry_t right_d;
    logic   left_g;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_d = ctl.ins;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_d = cell_data[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end

    sfrq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (cell_occ[i]),
      .left    (left_d),
      .left_gt (left_g),
      .right   (right_d),
      .data    (cell_data[i]),
      .gt      (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      capacity_limit <= LIMIT_RESET;
      done           <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
      if (cfg_we) begin
        capacity_limit <= cfg_wdata;
      end
    end
  end

  // Result register: loaded on each accepted beat and held until the next one.
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      out_size  <= ctl.remove ? cell_data[0].key : '0;
      out_tag   <= ctl.remove ? cell_data[0].tag : '0;
      occupancy <= OCC_W'(EXT_W'(count_next));
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result strobe missing after accepted command");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_INSERTED)) |-> (count == CNT_W'($past(count) + 1'b1)))
    else $error("insert did not grow the count by one");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_REMOVED)) |-> ((out_size == '0) && (out_tag == '0)))
    else $error("payload not zero on a beat without removed data");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> !(cell_data[1].key < cell_data[0].key))
    else $error("head of queue is not the smallest key");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

endmodule

/* hw/rtl/sfrq_cell.sv */
// One slot of the sorted chain: compare with the incoming key, shift up or down.
module sfrq_cell
  import sfrq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  entry_t    left,
  input  logic      left_gt,
  input  entry_t    right,
  output entry_t    data,
  output logic      gt
);

  entry_t data_next;

  // An empty slot counts as greater so the new entry lands at the tail.
  assign gt = !occ || (ctl.ins.key < data.key);

  always_comb begin
    data_next = data;
    priority if (ctl.insert) begin
      if (gt) begin
        data_next = left_gt ? left : ctl.ins;
      end
    end else if (ctl.remove) begin
      data_next = right;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
